// ----- rtl/rbfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfp_pkg: shared types and constants of the ring buffer FIFO with peek
// Holds the field widths, the opcode set, the status record that travels
// from the pointer control to the result stage, and the capacity clamp.
// ----------------------------------------------------------------------------
package rbfp_pkg;

   // Default number of ring entries built.
   localparam int DEPTH_DEF = 64;

   // Fixed field widths of the channels.
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int OP_W   = 2;

   // Capacity value after reset.
   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   // Request opcodes; the unused code is refused.
   typedef enum logic [OP_W-1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   // Status of one request, passed from the pointer control to the result stage.
   typedef struct packed {
      logic             ok;
      logic             rd;
      logic [CNT_W-1:0] count;
      logic             empty;
      logic             full;
   } rsp_tag_type;

   // Clamp a capacity write to the range 1 .. lim.
   function automatic logic [CNT_W-1:0] eff_cap_f(input logic [CNT_W-1:0] cap,
                                                  input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] c;
      c = cap;
      if (c == '0) begin
         c = {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (c > lim) begin
         c = lim;
      end
      return c;
   endfunction

endpackage

// ----- rtl/rbfp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfp_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module rbfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rbfp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfp_ctrl: pointer and count control of the ring buffer
// Keeps head, tail, count and the clamped capacity, decodes each request,
// issues the RAM write or read and reports the status after the operation.
// ----------------------------------------------------------------------------
module rbfp_ctrl #(
   parameter int DEPTH = rbfp_pkg::DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [rbfp_pkg::CNT_W-1:0]           csr_wr_data,
   input  logic                                 take,
   input  logic [rbfp_pkg::OP_W-1:0]            opcode,
   input  logic signed [rbfp_pkg::DATA_W-1:0]   value,
   input  logic [rbfp_pkg::IDX_W-1:0]           index,
   output logic                                 ram_wr_en,
   output logic [AW-1:0]                        ram_wr_addr,
   output logic [rbfp_pkg::DATA_W-1:0]          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [AW-1:0]                        ram_rd_addr,
   output logic                                 tag_valid,
   output rbfp_pkg::rsp_tag_type                tag
);
   import rbfp_pkg::*;

   // Largest usable capacity: the built depth, limited by the register width.
   localparam int CAP_MAX_I = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_MAX_I);

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             full_now;
   logic             empty_now;
   logic [CNT_W-1:0] head_adv;
   logic [CNT_W-1:0] tail_adv;
   logic [CNT_W:0]   peek_sum;
   logic [CNT_W-1:0] peek_pos;
   logic             ok;
   logic             wr;
   logic             rd;
   logic [CNT_W-1:0] rd_ptr;
   logic [CNT_W-1:0] cnt_next;

   assign full_now  = (count_ff == cap_ff);
   assign empty_now = (count_ff == '0);
   assign head_adv  = (head_ff + 1'b1 >= cap_ff) ? '0 : head_ff + 1'b1;
   assign tail_adv  = (tail_ff + 1'b1 >= cap_ff) ? '0 : tail_ff + 1'b1;

   // Peek position: head plus offset, wrapped once at the capacity.
   assign peek_sum = {1'b0, head_ff} + {{(CNT_W+1-IDX_W){1'b0}}, index};
   assign peek_pos = (peek_sum >= {1'b0, cap_ff}) ?
                     CNT_W'(peek_sum - {1'b0, cap_ff}) : peek_sum[CNT_W-1:0];

   // Request decode.
   always_comb begin
      ok       = 1'b0;
      wr       = 1'b0;
      rd       = 1'b0;
      rd_ptr   = head_ff;
      cnt_next = count_ff;
      case (op_type'(opcode))
         OP_ENQ: begin
            ok = !full_now;
            wr = !full_now;
            if (!full_now) begin
               cnt_next = count_ff + 1'b1;
            end
         end
         OP_DEQ: begin
            ok = !empty_now;
            rd = !empty_now;
            if (!empty_now) begin
               cnt_next = count_ff - 1'b1;
            end
         end
         OP_PEEK: begin
            ok     = ({{(CNT_W-IDX_W){1'b0}}, index} < count_ff);
            rd     = ok;
            rd_ptr = peek_pos;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Pointer, count and capacity next state.
   always_comb begin
      cap_in   = cap_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         cap_in   = eff_cap_f(csr_wr_data, CAP_MAX);
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (take) begin
         count_in = cnt_next;
         if (wr) begin
            tail_in = tail_adv;
         end
         if (rd && (op_type'(opcode) == OP_DEQ)) begin
            head_in = head_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= eff_cap_f(CAP_RESET, CAP_MAX);
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // RAM commands.
   assign ram_wr_en   = take && wr;
   assign ram_wr_addr = AW'(tail_ff);
   assign ram_wr_data = value;
   assign ram_rd_en   = take && rd;
   assign ram_rd_addr = AW'(rd_ptr);

   // Status after the operation.
   assign tag_valid = take;
   assign tag.ok    = ok;
   assign tag.rd    = rd;
   assign tag.count = cnt_next;
   assign tag.empty = (cnt_next == '0);
   assign tag.full  = (cnt_next == cap_ff);

endmodule

// ----- rtl/rbfp_rsp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfp_rsp: result stage of the ring buffer
// Holds the request status while the RAM read completes, then loads the
// output register; stalls the request side when both are occupied and rsp_stall is high.
// ----------------------------------------------------------------------------
module rbfp_rsp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tag_valid,
   input  rbfp_pkg::rsp_tag_type                tag,
   input  logic [rbfp_pkg::DATA_W-1:0]          rd_data,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [rbfp_pkg::DATA_W-1:0]   rsp_data,
   output logic [rbfp_pkg::CNT_W-1:0]           rsp_count,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_full_res
);
   import rbfp_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   rsp_tag_type s1_tag_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_ok_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [CNT_W-1:0]  out_count_ff;
   logic        out_empty_ff;
   logic        out_full_ff;
   logic        s1_adv;

   // The read stage moves on when the output register is free or being taken.
   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tag_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (tag_valid) begin
         s1_tag_ff <= tag;
      end
      if (s1_adv && s1_valid_ff) begin
         out_ok_ff    <= s1_tag_ff.ok;
         out_data_ff  <= (s1_tag_ff.ok && s1_tag_ff.rd) ? rd_data : '0;
         out_count_ff <= s1_tag_ff.count;
         out_empty_ff <= s1_tag_ff.empty;
         out_full_ff  <= s1_tag_ff.full;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_ok        = out_ok_ff;
   assign rsp_data      = out_data_ff;
   assign rsp_count     = out_count_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_full_res  = out_full_ff;

endmodule

// ----- rtl/ring_buffer_fifo_with_peek_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_peek_top: circular FIFO of 32-bit words with peek
// Each request carries an opcode (enqueue, dequeue, peek at an offset from
// the oldest entry) and yields exactly one response with a success flag,
// the word read, and the count, empty and full status after the operation.
// Request channel req_*, response channel rsp_*, both valid/stall; a
// transfer happens when valid is high and stall is low. csr_wr_en with
// csr_wr_data sets the capacity in use (clamped to 1 .. DEPTH) and empties
// the queue; write it only while no request is in flight.
// The response passes the registered RAM read, with its status held in the
// read stage, and then the output register.
// Throughput: one request per cycle while req_stall is low; pointers and
// count update at the request transfer, so a read in the next cycle already
// sees a write. Reset empties the queue and sets the capacity to 64. Entries
// are not cleared; only written entries are ever read.
// When the receiver stalls, the output register holds, the read stage holds
// one more result, and then req_stall rises until the output drains.
// ----------------------------------------------------------------------------
module ring_buffer_fifo_with_peek_top #(
   parameter int DEPTH = rbfp_pkg::DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [rbfp_pkg::CNT_W-1:0]           csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rbfp_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [rbfp_pkg::DATA_W-1:0]   req_value,
   input  logic [rbfp_pkg::IDX_W-1:0]           req_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [rbfp_pkg::DATA_W-1:0]   rsp_data,
   output logic [rbfp_pkg::CNT_W-1:0]           rsp_count,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_full_res
);
   import rbfp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              take;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   logic              tag_valid;
   rsp_tag_type       tag;

   // Request transfer.
   assign take = req_valid && !req_stall;

   // Pointer and count control.
   rbfp_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .opcode      (req_opcode),
      .value       (req_value),
      .index       (req_index),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .tag_valid   (tag_valid),
      .tag         (tag)
   );

   // Entry storage.
   rbfp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Read completion and output register.
   rbfp_rsp u_rsp (
      .clock         (clock),
      .reset         (reset),
      .tag_valid     (tag_valid),
      .tag           (tag),
      .rd_data       (ram_rd_data),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ok        (rsp_ok),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .rsp_full_res  (rsp_full_res)
   );

   // A request never writes and reads the RAM at once.
   a_no_wr_rd: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM write and read issued in the same cycle");

   // A refused operation returns zero data.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_data == '0))
      else $error("Refused response carries nonzero data");

   // Empty and full cannot both hold, since the capacity is at least one.
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_res && rsp_full_res))
      else $error("Response reports both empty and full");

   // Empty status agrees with the count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_count == '0)))
      else $error("Empty flag disagrees with count");

endmodule

// ----- tb/ring_buffer_fifo_with_peek_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_peek_checker: predicts and checks every response
// Watches the request, response and capacity ports of the ring buffer FIFO.
// It keeps its own copy of the ring, the pointers and the capacity. For each
// request transfer it queues the response that the block has to give, and it
// compares each response transfer with the oldest queued one.
// ----------------------------------------------------------------------------
module ring_buffer_fifo_with_peek_checker
   import rbfp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CNT_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [DATA_W-1:0]        req_value,
   input  logic [IDX_W-1:0]         req_index,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_ok,
   input  logic [DATA_W-1:0]        rsp_data,
   input  logic [CNT_W-1:0]         rsp_count,
   input  logic                     rsp_empty_res,
   input  logic                     rsp_full_res,
   output int                       fail_count,
   output int                       status_due_count
);

   // One response: success flag, word read and the status after the operation.
   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  count;
      logic              empty;
      logic              full;
   } ring_status_type;

   // Mirror of the ring contents, the pointers and the capacity register.
   logic [DATA_W-1:0] ring_words [DEPTH_DEF];
   logic [IDX_W-1:0]  head_ptr;
   logic [IDX_W-1:0]  tail_ptr;
   logic              ring_full;
   logic [CNT_W-1:0]  cap_reg;

   // Responses owed by the block, oldest first.
   ring_status_type status_due [$];
   ring_status_type status_got;
   ring_status_type status_want;

   // Capacity in use: zero counts as one, anything above the depth as the depth.
   function automatic logic [CNT_W-1:0] cap_in_use();
      logic [CNT_W-1:0] c;
      c = cap_reg;
      if (c == '0) begin
         c = CNT_W'(1);
      end
      if (c > DEPTH_DEF) begin
         c = CNT_W'(DEPTH_DEF);
      end
      return c;
   endfunction

   // Number of entries held, from the pointers and the full flag.
   function automatic logic [CNT_W-1:0] entries_held();
      logic [CNT_W-1:0] c;
      c = cap_in_use();
      if (ring_full) begin
         return c;
      end
      if (tail_ptr >= head_ptr) begin
         return {1'b0, tail_ptr} - {1'b0, head_ptr};
      end
      return c - ({1'b0, head_ptr} - {1'b0, tail_ptr});
   endfunction

   // Step a pointer forward, wrapping at the capacity in use.
   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
      logic [CNT_W-1:0] q;
      q = {1'b0, p} + CNT_W'(1);
      if (q >= cap_in_use()) begin
         q = '0;
      end
      return q[IDX_W-1:0];
   endfunction

   // Apply one request to the mirror and return the response it must give.
   function automatic ring_status_type ring_apply(input logic [OP_W-1:0]   op,
                                                  input logic [DATA_W-1:0] val,
                                                  input logic [IDX_W-1:0]  idx);
      ring_status_type r;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] c;
      logic [CNT_W-1:0] pos;
      r = '0;
      n = entries_held();
      c = cap_in_use();
      case (op)
         OP_ENQ: begin
            if (!ring_full) begin
               ring_words[tail_ptr] = val;
               tail_ptr = next_ptr(tail_ptr);
               if (tail_ptr == head_ptr) begin
                  ring_full = 1'b1;
               end
               r.ok = 1'b1;
            end
         end
         OP_DEQ: begin
            if (n != 0) begin
               r.data = ring_words[head_ptr];
               head_ptr = next_ptr(head_ptr);
               ring_full = 1'b0;
               r.ok = 1'b1;
            end
         end
         OP_PEEK: begin
            if (n != 0 && {1'b0, idx} < n) begin
               pos = {1'b0, head_ptr} + {1'b0, idx};
               if (pos >= c) begin
                  pos = pos - c;
               end
               r.data = ring_words[pos[IDX_W-1:0]];
               r.ok = 1'b1;
            end
         end
         default: begin
            // The unused opcode is refused and changes nothing.
         end
      endcase
      n = entries_held();
      r.count = n;
      r.empty = (n == 0);
      r.full  = (n == c);
      return r;
   endfunction

   // Sample all channels at the rising edge. Responses are checked before the
   // request of the same edge is applied, since a response is always older.
   always @(posedge clock) begin
      if (reset) begin
         head_ptr   = '0;
         tail_ptr   = '0;
         ring_full  = 1'b0;
         cap_reg    = CAP_RESET;
         fail_count = 0;
         status_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            status_got.ok    = rsp_ok;
            status_got.data  = rsp_data;
            status_got.count = rsp_count;
            status_got.empty = rsp_empty_res;
            status_got.full  = rsp_full_res;
            if (status_due.size() == 0) begin
               fail_count++;
               $display("%0t: expected no response, actual ok=%0b data=%0h count=%0d",
                        $time, rsp_ok, rsp_data, rsp_count);
            end else begin
               status_want = status_due.pop_front();
               if (status_got !== status_want) begin
                  fail_count++;
                  $display("%0t: expected ok=%0b data=%0h count=%0d empty=%0b full=%0b",
                           $time, status_want.ok, status_want.data, status_want.count,
                           status_want.empty, status_want.full);
                  $display("%0t: actual   ok=%0b data=%0h count=%0d empty=%0b full=%0b",
                           $time, status_got.ok, status_got.data, status_got.count,
                           status_got.empty, status_got.full);
               end
            end
         end
         // A capacity write also empties the queue.
         if (csr_wr_en) begin
            cap_reg   = csr_wr_data;
            head_ptr  = '0;
            tail_ptr  = '0;
            ring_full = 1'b0;
         end
         if (req_valid && !req_stall) begin
            status_due.push_back(ring_apply(req_opcode, req_value, req_index));
         end
      end
      status_due_count = status_due.size();
   end

endmodule

// ----- tb/tb_ring_buffer_fifo_with_peek_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_fifo_with_peek_top: stimulus and verdict for the ring FIFO
// Runs a directed sequence over the refusal and wrap cases, then phases of
// random enqueue, dequeue and peek bursts under several capacities and
// idling patterns. A checker beside the block predicts and compares every
// response; this module drives the ports, guards progress and reports.
// ----------------------------------------------------------------------------
module tb_ring_buffer_fifo_with_peek_top;
   import rbfp_pkg::*;

   // The unused opcode, sent as noise.
   localparam logic [OP_W-1:0] OP_BAD = 2'd3;

   localparam int NUM_PHASES     = 10;
   localparam int PHASE_ITEMS    = 183;
   localparam int HOLD_PHASE     = 3;
   localparam int PAUSE_PHASE    = 6;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CNT_W-1:0]         csr_wr_data;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_opcode;
   logic signed [DATA_W-1:0] req_value;
   logic [IDX_W-1:0]         req_index;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_data;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_empty_res;
   logic                     rsp_full_res;

   int fail_count;
   int status_due_count;

   // Idling controls shared by the sender and the receiver.
   int gap_pct;
   int stall_pct;
   bit hold_off_req;

   // Capacity in use as the sender sees it, to aim peek offsets.
   int cap_now;

   ring_buffer_fifo_with_peek_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ok        (rsp_ok),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .rsp_full_res  (rsp_full_res)
   );

   ring_buffer_fifo_with_peek_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_data         (rsp_data),
      .rsp_count        (rsp_count),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_full_res     (rsp_full_res),
      .fail_count       (fail_count),
      .status_due_count (status_due_count)
   );

   // 10 ns clock.
   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("ring_buffer_fifo_with_peek_top: mismatch");
      $finish;
   end

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Offer one request from a falling edge until its transfer, with random
   // idle cycles ahead of it. Returns at the next falling edge.
   task automatic send_request(input logic [OP_W-1:0]   op,
                               input logic [DATA_W-1:0] val,
                               input logic [IDX_W-1:0]  idx);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      req_index  <= idx;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stop offering and wait until every response has come, plus the latency.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (status_due_count != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Write the capacity register while the block is idle.
   task automatic set_capacity(input logic [CNT_W-1:0] cap);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cap_now = (cap == 0) ? 1 : ((cap > DEPTH_DEF) ? DEPTH_DEF : int'(cap));
   endtask

   // One random request, leaning toward filling or toward draining the queue.
   task automatic send_random(input bit fill);
      int r;
      int idx_lim;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] val;
      logic [IDX_W-1:0]  idx;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         op = OP_BAD;
      end else if (r < 15) begin
         op = OP_PEEK;
      end else if (fill ? (r < 85) : (r < 30)) begin
         op = OP_ENQ;
      end else begin
         op = OP_DEQ;
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               val = 32'h8000_0000;
            end
            1: begin
               val = 32'h7FFF_FFFF;
            end
            2: begin
               val = 32'h0000_0000;
            end
            default: begin
               val = 32'hFFFF_FFFF;
            end
         endcase
      end else begin
         val = $urandom();
      end
      // Peek offsets mostly near the live range, sometimes anywhere.
      idx_lim = (cap_now > 63) ? 63 : cap_now;
      if ($urandom_range(0, 4) == 0) begin
         idx = IDX_W'($urandom_range(0, 63));
      end else begin
         idx = IDX_W'($urandom_range(0, idx_lim));
      end
      send_request(op, val, idx);
   endtask

   // Main sequence: reset, directed cases, random phases, verdict.
   initial begin
      int p;
      int k;
      int burst_left;
      bit fill;
      logic [CNT_W-1:0] cap;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_opcode   = OP_ENQ;
      req_value    = '0;
      req_index    = '0;
      gap_pct      = 0;
      stall_pct    = 0;
      hold_off_req = 1'b0;
      cap_now      = DEPTH_DEF;
      burst_left   = 0;
      fill         = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: refusals when empty, fill to full, refusal when full, peek
      // offsets inside and beyond the count, and wrap of both pointers.
      set_capacity(7'd4);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_PEEK, 32'h0, 6'd0);
      send_request(OP_BAD, 32'h0, 6'd0);
      send_request(OP_ENQ, 32'h7FFF_FFFF, 6'd63);
      send_request(OP_ENQ, 32'h8000_0000, 6'd0);
      send_request(OP_ENQ, 32'h0000_0000, 6'd0);
      send_request(OP_ENQ, 32'hFFFF_FFFF, 6'd0);
      send_request(OP_ENQ, 32'h0000_0005, 6'd0);
      send_request(OP_BAD, 32'hFFFF_FFFF, 6'd63);
      send_request(OP_PEEK, 32'h0, 6'd0);
      send_request(OP_PEEK, 32'h0, 6'd3);
      send_request(OP_PEEK, 32'h0, 6'd4);
      send_request(OP_PEEK, 32'hFFFF_FFFF, 6'd63);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_ENQ, 32'h0000_007B, 6'd0);
      send_request(OP_ENQ, 32'h0000_01C8, 6'd0);
      send_request(OP_PEEK, 32'h0, 6'd3);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);
      // A single-entry queue.
      set_capacity(7'd1);
      send_request(OP_ENQ, 32'h1234_5678, 6'd0);
      send_request(OP_ENQ, 32'h0BAD_0BAD, 6'd0);
      send_request(OP_PEEK, 32'h0, 6'd0);
      send_request(OP_DEQ, 32'h0, 6'd0);

      // Random phases over several capacities and idling patterns.
      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               cap = 7'd64;
            end
            1: begin
               cap = 7'd1;
            end
            2: begin
               cap = 7'd0;
            end
            3: begin
               cap = 7'd127;
            end
            4: begin
               cap = 7'd5;
            end
            5: begin
               cap = 7'd2;
            end
            6: begin
               cap = CNT_W'($urandom_range(1, 64));
            end
            7: begin
               cap = 7'd17;
            end
            8: begin
               cap = CNT_W'($urandom_range(3, 12));
            end
            default: begin
               cap = 7'd64;
            end
         endcase
         set_capacity(cap);
         case (p % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 45;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 45;
            end
            default: begin
               gap_pct   = 11;
               stall_pct = 11;
            end
         endcase
         // The receiver holds off while requests keep coming, so the block
         // backs up and stalls its input.
         if (p == HOLD_PHASE) begin
            hold_off_req = 1'b1;
         end
         burst_left = 0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 2 * cap_now + 2);
               fill = 1'($urandom_range(0, 1));
            end
            burst_left--;
            if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
               drain_responses();
            end
            send_random(fill);
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ring_buffer_fifo_with_peek_top: match");
      end else begin
         $display("ring_buffer_fifo_with_peek_top: mismatch");
      end
      $finish;
   end

endmodule
